// ===== design/atsc_pkg.sv =====
// ----------------------------------------------------------------------------
// atsc_pkg
// shared widths, cell bus types and the arctangent table for the tilt block
// ----------------------------------------------------------------------------
package atsc_pkg;

    // cell counts of the three kinds of chains and the atan table length
    localparam int SQRT_CELLS   = 16;
    localparam int DIV_CELLS    = 17;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    // cycles from an accepted word to its result strobe
    localparam int LATENCY = 9 + 3 * SQRT_CELLS + 2 * DIV_CELLS + CORDIC_STEPS;

    localparam int ROOT_IDX_W = 4;
    localparam int ROOT_V_W   = 33;
    localparam int REM_W      = 31;
    localparam int DEN_W      = 16;
    localparam int QUO_W      = 17;
    localparam int DIV_IDX_W  = 5;
    localparam int ROT_W      = 27;
    localparam int ANG_W      = 33;
    localparam int ROT_IDX_W  = 5;

    localparam logic signed [9:0] OFFSET_X_RST = -10'sd30;
    localparam logic signed [9:0] OFFSET_Y_RST = 10'sd12;

    typedef enum logic [1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1
    } cfg_idx_t;

    // integer square root cell bus
    typedef struct packed {
        logic [ROOT_V_W-1:0] v;
        logic [ROOT_V_W-1:0] res;
    } root_t;

    // restoring divider cell bus
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } quot_t;

    // cordic vectoring cell bus
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } rot_t;

    // per-sample context carried alongside the cell chains
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               zl;
        logic               ovf;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [15:0]        c;
        logic signed [16:0] t;
    } ctx_t;

    // atan(2^-i) where pi is 2^31
    function automatic logic [31:0] atan_entry(input logic [ROT_IDX_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10680094;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/accel_tilt_servo_correction.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_servo_correction
// accelerometer tilt angles and halved servo step deltas, fully pipelined
// ----------------------------------------------------------------------------
// channel   | handshake               | payload
// ----------+-------------------------+---------------------------------------
// sample in | start & !busy           | accel_x/y/z, desired_x/y
// result    | done (one-cycle strobe) | tilt_x/y, servo_step_x/y, zero_length
// config    | cfg_valid & cfg_ready   | cfg_index, cfg_data
//
// one word accepted every cycle, busy never rises
// each result follows its word through the capture and square registers, three square
// root chains, two divider chains and the cordic chain, then the scaling and output registers
// reset clears the valid line and loads the offset reset values
// the receiver cannot stall: results are strobed once and not held
// ----------------------------------------------------------------------------
module accel_tilt_servo_correction
    import atsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] desired_x,
    input  logic signed [15:0] desired_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    output logic               done,
    output logic signed [9:0]  tilt_x,
    output logic signed [9:0]  tilt_y,
    output logic signed [15:0] servo_step_x,
    output logic signed [15:0] servo_step_y,
    output logic               zero_length
);

    // trunc(p / 2^31) clamped to +-500
    function automatic logic signed [9:0] to_milli(input logic signed [42:0] p);
        logic signed [42:0] b;
        logic signed [11:0] q;
        logic signed [9:0]  r;
        b = p + ((p < 0) ? 43'sd2147483647 : 43'sd0);
        q = 12'(b >>> 31);
        if (q > 12'sd500)
            r = 10'sd500;
        else if (q < -12'sd500)
            r = -10'sd500;
        else
            r = q[9:0];
        return r;
    endfunction

    // trunc(n / 2) saturated to 16 bits
    function automatic logic signed [15:0] half_sat(input logic signed [17:0] n);
        logic signed [17:0] h;
        logic signed [15:0] r;
        h = (n + ((n < 0) ? 18'sd1 : 18'sd0)) >>> 1;
        if (h > 18'sd32767)
            r = 16'sh7fff;
        else if (h < -18'sd32768)
            r = 16'sh8000;
        else
            r = h[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------ config
    logic signed [9:0] offset_x_reg;
    logic signed [9:0] offset_y_reg;
    cfg_idx_t          cfg_sel;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign cfg_sel   = cfg_idx_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= OFFSET_X_RST;
            offset_y_reg <= OFFSET_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_sel)
                CFG_OFFSET_X: offset_x_reg <= cfg_data;
                CFG_OFFSET_Y: offset_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // -------------------------------------------------------------- valid line
    logic [LATENCY-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LATENCY-2:0], start & ~busy};
    end

    // ----------------------------------------------------- capture and squares
    ctx_t        ctx_a_reg;
    ctx_t        ctx_b_reg;
    logic [30:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [15:0] az_reg;
    logic signed [31:0] px, py, pz;

    always_ff @(posedge clk)
    begin
        ctx_a_reg <= '{ax: accel_x, ay: accel_y, dx: desired_x, dy: desired_y,
                       default: '0};
        az_reg    <= accel_z;
    end

    assign px = ctx_a_reg.ax * ctx_a_reg.ax;
    assign py = ctx_a_reg.ay * ctx_a_reg.ay;
    assign pz = az_reg * az_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg   <= px[30:0];
        sqy_reg   <= py[30:0];
        sqz_reg   <= pz[30:0];
        ctx_b_reg <= ctx_a_reg;
    end

    // ----------------------------------------------------- vector length root
    root_t s1_bus [SQRT_CELLS+1];
    ctx_t  s1_ctx_reg [SQRT_CELLS];

    assign s1_bus[0].v   = ROOT_V_W'({1'b0, sqx_reg}) + ROOT_V_W'({1'b0, sqy_reg})
                         + ROOT_V_W'({1'b0, sqz_reg});
    assign s1_bus[0].res = '0;

    genvar k;
    generate
        for (k = 0; k < SQRT_CELLS; k++)
        begin : g_s1
            atsc_sqrt_cell u_cell (
                .clk  (clk),
                .idx  (ROOT_IDX_W'(SQRT_CELLS - 1 - k)),
                .din  (s1_bus[k]),
                .dout (s1_bus[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        s1_ctx_reg[0] <= ctx_b_reg;
        for (int i = 1; i < SQRT_CELLS; i++)
            s1_ctx_reg[i] <= s1_ctx_reg[i-1];
    end

    // --------------------------------------------------- normalize x and y
    logic [15:0] len;
    ctx_t        d1_in;
    logic [15:0] magx, magy;
    quot_t       dx_bus [DIV_CELLS+1];
    quot_t       dy_bus [DIV_CELLS+1];
    ctx_t        d1_ctx_reg [DIV_CELLS];

    assign len  = s1_bus[SQRT_CELLS].res[15:0];
    assign magx = s1_ctx_reg[SQRT_CELLS-1].ax[15] ? 16'(-s1_ctx_reg[SQRT_CELLS-1].ax)
                                                  : 16'(s1_ctx_reg[SQRT_CELLS-1].ax);
    assign magy = s1_ctx_reg[SQRT_CELLS-1].ay[15] ? 16'(-s1_ctx_reg[SQRT_CELLS-1].ay)
                                                  : 16'(s1_ctx_reg[SQRT_CELLS-1].ay);

    always_comb
    begin
        d1_in    = s1_ctx_reg[SQRT_CELLS-1];
        d1_in.zl = (len == '0);
    end

    assign dx_bus[0] = '{rem: {magx, 15'b0}, den: len, quo: '0};
    assign dy_bus[0] = '{rem: {magy, 15'b0}, den: len, quo: '0};

    generate
        for (k = 0; k < DIV_CELLS; k++)
        begin : g_d1
            atsc_div_cell u_cx (
                .clk  (clk),
                .idx  (DIV_IDX_W'(DIV_CELLS - 1 - k)),
                .din  (dx_bus[k]),
                .dout (dx_bus[k+1])
            );
            atsc_div_cell u_cy (
                .clk  (clk),
                .idx  (DIV_IDX_W'(DIV_CELLS - 1 - k)),
                .din  (dy_bus[k]),
                .dout (dy_bus[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        d1_ctx_reg[0] <= d1_in;
        for (int i = 1; i < DIV_CELLS; i++)
            d1_ctx_reg[i] <= d1_ctx_reg[i-1];
    end

    // signed ratios, then y squared
    ctx_t        ctx_e_reg, ctx_e_next;
    ctx_t        ctx_f_reg;
    logic [30:0] ysq_reg;
    logic signed [33:0] yp;

    always_comb
    begin
        ctx_e_next   = d1_ctx_reg[DIV_CELLS-1];
        ctx_e_next.x = ctx_e_next.ax[15] ? -$signed(dx_bus[DIV_CELLS].quo)
                                         : $signed(dx_bus[DIV_CELLS].quo);
        ctx_e_next.y = ctx_e_next.ay[15] ? -$signed(dy_bus[DIV_CELLS].quo)
                                         : $signed(dy_bus[DIV_CELLS].quo);
    end

    assign yp = ctx_e_reg.y * ctx_e_reg.y;

    always_ff @(posedge clk)
    begin
        ctx_e_reg <= ctx_e_next;
        ysq_reg   <= yp[30:0];
        ctx_f_reg <= ctx_e_reg;
    end

    // ------------------------------------------------ c = sqrt(1 - y^2)
    root_t s2_bus [SQRT_CELLS+1];
    ctx_t  s2_ctx_reg [SQRT_CELLS];

    assign s2_bus[0].v   = (ROOT_V_W'(1) << 30) - ROOT_V_W'(ysq_reg);
    assign s2_bus[0].res = '0;

    generate
        for (k = 0; k < SQRT_CELLS; k++)
        begin : g_s2
            atsc_sqrt_cell u_cell (
                .clk  (clk),
                .idx  (ROOT_IDX_W'(SQRT_CELLS - 1 - k)),
                .din  (s2_bus[k]),
                .dout (s2_bus[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        s2_ctx_reg[0] <= ctx_f_reg;
        for (int i = 1; i < SQRT_CELLS; i++)
            s2_ctx_reg[i] <= s2_ctx_reg[i-1];
    end

    // ---------------------------------------------------- t = x / c
    ctx_t        d2_in;
    logic [15:0] magt;
    quot_t       dt_bus [DIV_CELLS+1];
    ctx_t        d2_ctx_reg [DIV_CELLS];

    assign magt = s2_ctx_reg[SQRT_CELLS-1].x[16] ? 16'(-s2_ctx_reg[SQRT_CELLS-1].x)
                                                 : 16'(s2_ctx_reg[SQRT_CELLS-1].x);

    always_comb
    begin
        d2_in     = s2_ctx_reg[SQRT_CELLS-1];
        d2_in.c   = s2_bus[SQRT_CELLS].res[15:0];
        // quotient of 2^17 or more always clamps, also covers c of zero
        d2_in.ovf = {2'b00, magt[15:2]} >= s2_bus[SQRT_CELLS].res[15:0];
    end

    assign dt_bus[0] = '{rem: {magt, 15'b0}, den: s2_bus[SQRT_CELLS].res[15:0],
                         quo: '0};

    generate
        for (k = 0; k < DIV_CELLS; k++)
        begin : g_d2
            atsc_div_cell u_cell (
                .clk  (clk),
                .idx  (DIV_IDX_W'(DIV_CELLS - 1 - k)),
                .din  (dt_bus[k]),
                .dout (dt_bus[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        d2_ctx_reg[0] <= d2_in;
        for (int i = 1; i < DIV_CELLS; i++)
            d2_ctx_reg[i] <= d2_ctx_reg[i-1];
    end

    // clamp t, then t squared
    ctx_t        ctx_g_reg, ctx_g_next;
    ctx_t        ctx_h_reg;
    logic [30:0] tsq_reg;
    logic [16:0] tmag;
    logic signed [33:0] tp;

    always_comb
    begin
        ctx_g_next = d2_ctx_reg[DIV_CELLS-1];
        if (ctx_g_next.ovf || dt_bus[DIV_CELLS].quo > 17'd32768)
            tmag = 17'd32768;
        else
            tmag = dt_bus[DIV_CELLS].quo;
        if (ctx_g_next.x == '0)
            ctx_g_next.t = '0;
        else if (ctx_g_next.x < 0)
            ctx_g_next.t = -$signed(tmag);
        else
            ctx_g_next.t = $signed(tmag);
    end

    assign tp = ctx_g_reg.t * ctx_g_reg.t;

    always_ff @(posedge clk)
    begin
        ctx_g_reg <= ctx_g_next;
        tsq_reg   <= tp[30:0];
        ctx_h_reg <= ctx_g_reg;
    end

    // ------------------------------------------------ sqrt(1 - t^2)
    root_t s3_bus [SQRT_CELLS+1];
    ctx_t  s3_ctx_reg [SQRT_CELLS];

    assign s3_bus[0].v   = (ROOT_V_W'(1) << 30) - ROOT_V_W'(tsq_reg);
    assign s3_bus[0].res = '0;

    generate
        for (k = 0; k < SQRT_CELLS; k++)
        begin : g_s3
            atsc_sqrt_cell u_cell (
                .clk  (clk),
                .idx  (ROOT_IDX_W'(SQRT_CELLS - 1 - k)),
                .din  (s3_bus[k]),
                .dout (s3_bus[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        s3_ctx_reg[0] <= ctx_h_reg;
        for (int i = 1; i < SQRT_CELLS; i++)
            s3_ctx_reg[i] <= s3_ctx_reg[i-1];
    end

    // ------------------------------------------- asin via cordic atan2, both
    rot_t ry_bus [CORDIC_STEPS+1];
    rot_t rt_bus [CORDIC_STEPS+1];
    ctx_t r_ctx_reg [CORDIC_STEPS];
    ctx_t r_in;

    assign r_in = s3_ctx_reg[SQRT_CELLS-1];

    // operands scaled by 256
    assign ry_bus[0].x = ROT_W'({r_in.c, 8'b0});
    assign ry_bus[0].y = ROT_W'(r_in.y) <<< 8;
    assign ry_bus[0].z = '0;
    assign rt_bus[0].x = ROT_W'({s3_bus[SQRT_CELLS].res[15:0], 8'b0});
    assign rt_bus[0].y = ROT_W'(r_in.t) <<< 8;
    assign rt_bus[0].z = '0;

    generate
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_rot
            atsc_cordic_cell u_ry (
                .clk  (clk),
                .idx  (ROT_IDX_W'(k)),
                .din  (ry_bus[k]),
                .dout (ry_bus[k+1])
            );
            atsc_cordic_cell u_rt (
                .clk  (clk),
                .idx  (ROT_IDX_W'(k)),
                .din  (rt_bus[k]),
                .dout (rt_bus[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        r_ctx_reg[0] <= r_in;
        for (int i = 1; i < CORDIC_STEPS; i++)
            r_ctx_reg[i] <= r_ctx_reg[i-1];
    end

    // -------------------------------------------- angle scaling and servo
    logic signed [42:0] prod_y_reg, prod_t_reg;
    logic signed [9:0]  ang_y_reg, ang_t_reg;
    ctx_t               ctx_i_reg, ctx_j_reg;

    always_ff @(posedge clk)
    begin
        prod_y_reg <= ry_bus[CORDIC_STEPS].z * 43'sd1000;
        prod_t_reg <= rt_bus[CORDIC_STEPS].z * 43'sd1000;
        ctx_i_reg  <= r_ctx_reg[CORDIC_STEPS-1];
        ang_y_reg  <= to_milli(prod_y_reg);
        ang_t_reg  <= to_milli(prod_t_reg);
        ctx_j_reg  <= ctx_i_reg;
    end

    // zero length forces both angles to zero, servo steps still formed
    logic signed [9:0]  tx_next, ty_next;
    logic signed [17:0] nx, ny;
    logic signed [9:0]  tilt_x_reg, tilt_y_reg;
    logic signed [15:0] servo_x_reg, servo_y_reg;
    logic               zl_reg;

    assign tx_next = ctx_j_reg.zl ? 10'sd0 : -ang_t_reg;
    assign ty_next = ctx_j_reg.zl ? 10'sd0 : ang_y_reg;
    assign nx = -(18'(ctx_j_reg.dy) - 18'(tx_next) + 18'(offset_x_reg));
    assign ny = 18'(ctx_j_reg.dx) - 18'(ty_next) + 18'(offset_y_reg);

    always_ff @(posedge clk)
    begin
        tilt_x_reg  <= tx_next;
        tilt_y_reg  <= ty_next;
        servo_x_reg <= half_sat(nx);
        servo_y_reg <= half_sat(ny);
        zl_reg      <= ctx_j_reg.zl;
    end

    assign done         = valid_reg[LATENCY-1];
    assign tilt_x       = tilt_x_reg;
    assign tilt_y       = tilt_y_reg;
    assign servo_step_x = servo_x_reg;
    assign servo_step_y = servo_y_reg;
    assign zero_length  = zl_reg;

    // ---------------------------------------------------------------- checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LATENCY) done)
        else $error("result strobe missing after accepted word");

    a_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_length) |-> (tilt_x == 10'sd0 && tilt_y == 10'sd0))
        else $error("zero length with nonzero angle");

    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tilt_x >= -10'sd500 && tilt_x <= 10'sd500 &&
                  tilt_y >= -10'sd500 && tilt_y <= 10'sd500))
        else $error("tilt angle out of range");

endmodule

// ===== design/atsc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// atsc_sqrt_cell
// one result bit of a pipelined integer square root
// ----------------------------------------------------------------------------
module atsc_sqrt_cell
    import atsc_pkg::*;
(
    input  logic                  clk,
    input  logic [ROOT_IDX_W-1:0] idx,
    input  root_t                 din,
    output root_t                 dout
);

    logic [ROOT_V_W-1:0] one;
    logic [ROOT_V_W-1:0] trial;
    root_t               dout_next;
    root_t               dout_reg;

    always_comb
    begin
        one   = ROOT_V_W'(1) << {idx, 1'b0};
        trial = din.res + one;
        if (din.v >= trial)
        begin
            dout_next.v   = din.v - trial;
            dout_next.res = (din.res >> 1) + one;
        end
        else
        begin
            dout_next.v   = din.v;
            dout_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== design/atsc_div_cell.sv =====
// ----------------------------------------------------------------------------
// atsc_div_cell
// one quotient bit of a pipelined restoring divider
// ----------------------------------------------------------------------------
module atsc_div_cell
    import atsc_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_IDX_W-1:0] idx,
    input  quot_t                din,
    output quot_t                dout
);

    logic [REM_W+1:0] sub;
    quot_t            dout_next;
    quot_t            dout_reg;

    always_comb
    begin
        sub       = (REM_W+2)'(din.den) << idx;
        dout_next = din;
        if ({2'b00, din.rem} >= sub)
        begin
            dout_next.rem = din.rem - sub[REM_W-1:0];
            dout_next.quo = din.quo | (QUO_W'(1) << idx);
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== design/atsc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// atsc_cordic_cell
// one vectoring rotation of a pipelined cordic arctangent
// ----------------------------------------------------------------------------
module atsc_cordic_cell
    import atsc_pkg::*;
(
    input  logic                 clk,
    input  logic [ROT_IDX_W-1:0] idx,
    input  rot_t                 din,
    output rot_t                 dout
);

    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic signed [ANG_W-1:0] a;
    rot_t                    dout_next;
    rot_t                    dout_reg;

    always_comb
    begin
        dx = din.y >>> idx;
        dy = din.x >>> idx;
        a  = $signed({1'b0, atan_entry(idx)});
        if (din.y > 0)
        begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + a;
        end
        else
        begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - a;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== tb/sv/accel_tilt_servo_correction_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_tilt_servo_correction_tb
// drives accelerometer samples and desired positions into the tilt block,
// predicts tilt angles and servo steps in fixed point, and checks every
// strobed result in order against the predicted queue
// ----------------------------------------------------------------------------
module accel_tilt_servo_correction_tb;
    import atsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
    localparam int RANDOM_WORDS   = 600;

    // one predicted result word
    typedef struct packed {
        logic signed [9:0]  tx;
        logic signed [9:0]  ty;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               zl;
    } tilt_res_t;

    // one directed stimulus row; chk marks a hand-typed expectation
    typedef struct {
        logic signed [15:0] ax, ay, az, dx, dy;
        bit                 chk;
        tilt_res_t          res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [15:0] desired_x = '0, desired_y = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [9:0]         cfg_data = '0;
    logic               done;
    logic signed [9:0]  tilt_x, tilt_y;
    logic signed [15:0] servo_step_x, servo_step_y;
    logic               zero_length;

    accel_tilt_servo_correction u_dut (.*);

    always #1 clk = ~clk;

    // predictor copy of the two offset registers
    logic signed [9:0] pred_off_x = OFFSET_X_RST;
    logic signed [9:0] pred_off_y = OFFSET_Y_RST;

    tilt_res_t expected_q[$];
    int        mismatches = 0;
    int        words_in = 0;
    int        results_seen = 0;
    int        zero_len_seen = 0;
    int        idle_cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // atan table entry, pi = 2^31
    function automatic longint atan_step(int i);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10680094, 5340245, 2670163, 1335087, 667544,
                          333772, 166886, 83443, 41722, 20861, 10430, 5215,
                          2608, 1304, 652, 326, 163, 81};
        return t[i];
    endfunction

    // asin of a q1.15 ratio via cordic vectoring, thousandths of 180 deg
    function automatic longint asin_milli(longint v);
        longint cx, x, y, z, ddx, ddy;
        cx = longint'(int_sqrt(64'(longint'(32768) * 32768 - v * v)));
        x = cx * 256;
        y = v * 256;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            ddx = y >>> i;   // arithmetic, rounds toward minus infinity
            ddy = x >>> i;
            if (y > 0) begin
                x += ddx; y -= ddy; z += atan_step(i);
            end else begin
                x -= ddx; y += ddy; z -= atan_step(i);
            end
        end
        return clip((z * 1000) / 64'sd2147483648, -500, 500);
    endfunction

    function automatic tilt_res_t predict_tilt(longint ax, longint ay, longint az,
                                               longint dx, longint dy);
        tilt_res_t r;
        longint len, x, y, c, t, tx = 0, ty = 0;
        len = longint'(int_sqrt(64'(ax * ax + ay * ay + az * az)));
        if (len != 0) begin
            x = clip((ax * 32768) / len, -32768, 32768);
            y = clip((ay * 32768) / len, -32768, 32768);
            c = longint'(int_sqrt(64'(longint'(32768) * 32768 - y * y)));
            if (c == 0) t = x > 0 ? 32768 : (x < 0 ? -32768 : 0);
            else        t = clip((x * 32768) / c, -32768, 32768);
            ty = asin_milli(y);
            tx = -asin_milli(t);
        end
        r.tx = 10'(tx);
        r.ty = 10'(ty);
        r.sx = 16'(clip((-(dy - tx + longint'(pred_off_x))) / 2, -32768, 32767));
        r.sy = 16'(clip((dx - ty + longint'(pred_off_y)) / 2, -32768, 32767));
        r.zl = (len == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
        mismatches++;
    endtask

    // result monitor, sampled at the edge that ends the strobe cycle
    always @(posedge clk) begin
        if (rst_n && done) begin
            tilt_res_t e;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                e = expected_q.pop_front();
                if (tilt_x != e.tx)       report_mismatch("tilt_x", tilt_x, e.tx);
                if (tilt_y != e.ty)       report_mismatch("tilt_y", tilt_y, e.ty);
                if (servo_step_x != e.sx) report_mismatch("servo_step_x", servo_step_x, e.sx);
                if (servo_step_y != e.sy) report_mismatch("servo_step_y", servo_step_y, e.sy);
                if (zero_length != e.zl)  report_mismatch("zero_length", zero_length, e.zl);
                if (e.zl) zero_len_seen++;
            end
            results_seen++;
        end
    end

    // watchdog: cycles with no accepted sample, config write or result strobe
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("accel_tilt_servo_correction_tb NOT OK");
            $finish;
        end
    end

    // register write, only while idle; the predictor follows
    task automatic write_offset(input cfg_idx_t idx, input logic signed [9:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OFFSET_X) pred_off_x = val;
        else                     pred_off_y = val;
    endtask

    // one word through the start/busy handshake; gap is the idle before it
    // entered and left at a rising edge, so the next word follows at once
    task automatic send_sample(input logic signed [15:0] ax, ay, az, dx, dy,
                               input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        accel_x   <= ax;
        accel_y   <= ay;
        accel_z   <= az;
        desired_x <= dx;
        desired_y <= dy;
        expected_q.push_back(predict_tilt(ax, ay, az, dx, dy));
        words_in++;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // called at the edge that accepted the last word
    task automatic finish_start();
        start <= 1'b0;
    endtask

    // drain the pipeline so registers can be written safely
    task automatic drain();
        finish_start();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // random sample: mostly realistic gravity vectors, some full-range noise, some near zero
    task automatic random_sample(input bit with_idle);
        logic signed [15:0] a[3];
        int k, gap;
        k = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            if (k < 6)      a[i] = $signed(16'($urandom_range(0, 33000))) - 16'sd16500;
            else if (k < 8) a[i] = 16'($urandom);
            else            a[i] = $signed(16'($urandom_range(0, 6))) - 16'sd3;
        end
        if (k == 9 && $urandom_range(0, 1)) a[2] = '0;
        gap = (with_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        send_sample(a[0], a[1], a[2], 16'($urandom), 16'($urandom), gap);
    endtask

    stim_row_t dir_rows[$];

    function automatic stim_row_t row(longint ax, ay, az, dx, dy, bit chk = 0,
                                      longint tx = 0, ty = 0, sx = 0, sy = 0,
                                      bit zl = 0);
        stim_row_t r;
        r.ax = 16'(ax); r.ay = 16'(ay); r.az = 16'(az);
        r.dx = 16'(dx); r.dy = 16'(dy); r.chk = chk;
        r.res.tx = 10'(tx); r.res.ty = 10'(ty);
        r.res.sx = 16'(sx); r.res.sy = 16'(sy); r.res.zl = zl;
        return r;
    endfunction

    initial begin
        tilt_res_t p;
        int gap;

        // zero vector with reset offsets: angles forced to zero
        dir_rows.push_back(row(0, 0, 0, 0, 0, 1, 0, 0, 15, 6, 1));
        // zero vector, extreme desired positions
        dir_rows.push_back(row(0, 0, 0, 32767, -32768, 1, 0, 0, 16399, 16389, 1));
        // flat: straight down the z axis
        dir_rows.push_back(row(0, 0, 16384, 100, -100, 1, 0, 0, 65, 56, 0));
        // pure y axis: zero denominator, x zero
        dir_rows.push_back(row(0, 16384, 0, 0, 0));
        dir_rows.push_back(row(0, -32768, 0, 0, 0));
        // pure x axis
        dir_rows.push_back(row(32767, 0, 0, 0, 0));
        dir_rows.push_back(row(-32768, 0, 0, 0, 0));
        // zero denominator with nonzero x
        dir_rows.push_back(row(1, 32767, 0, 0, 0));
        dir_rows.push_back(row(-1, -32768, 0, 0, 0));
        // all extremes, then small and mixed vectors
        dir_rows.push_back(row(-32768, -32768, -32768, -32768, -32768));
        dir_rows.push_back(row(32767, 32767, 32767, 32767, 32767));
        dir_rows.push_back(row(-32768, 32767, -32768, 32767, -32768));
        dir_rows.push_back(row(1, 1, 1, -1, 1));
        dir_rows.push_back(row(1, 0, 0, 0, 0));
        dir_rows.push_back(row(0, -1, 0, 0, 0));
        dir_rows.push_back(row(12000, -9000, 14000, 250, -400));
        dir_rows.push_back(row(-5000, 7000, -16000, -1234, 4321));
        dir_rows.push_back(row(21845, 21845, 21845, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table with reset offsets; hand values checked first
        foreach (dir_rows[i]) begin
            if (dir_rows[i].chk) begin
                p = predict_tilt(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az,
                                 dir_rows[i].dx, dir_rows[i].dy);
                if (p != dir_rows[i].res)
                    report_mismatch("directed table row", i, 0);
            end
            send_sample(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az,
                        dir_rows[i].dx, dir_rows[i].dy, 0);
        end
        drain();

        // offset extremes, zero, a random setting and the reset values, each with a random phase
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_offset(CFG_OFFSET_X, -10'sd512); write_offset(CFG_OFFSET_Y, 10'sd511); end
                1: begin write_offset(CFG_OFFSET_X, 10'sd511);  write_offset(CFG_OFFSET_Y, -10'sd512); end
                2: begin write_offset(CFG_OFFSET_X, 10'sd0);    write_offset(CFG_OFFSET_Y, 10'sd0); end
                3: begin write_offset(CFG_OFFSET_X, 10'($urandom)); write_offset(CFG_OFFSET_Y, 10'($urandom)); end
                default: begin write_offset(CFG_OFFSET_X, OFFSET_X_RST); write_offset(CFG_OFFSET_Y, OFFSET_Y_RST); end
            endcase
            // zero vector hits the servo path with each offset
            send_sample(0, 0, 0, 16'($urandom), 16'($urandom), 0);
            for (int n = 0; n < RANDOM_WORDS / 5; n++)
                random_sample(ph < 4);    // last phase runs back to back
            drain();
        end

        $display("%0d samples, %0d results checked (%0d zero-length), offsets swept",
                 words_in, results_seen, zero_len_seen);
        $display("offset registers taken through both extremes, zero and reset values");
        if (mismatches == 0)
            $display("accel_tilt_servo_correction_tb OK");
        else
            $display("accel_tilt_servo_correction_tb NOT OK");
        $finish;
    end

endmodule
